>>> rtl/decimal_text_to_int32_parser_defines.svh
// ---------------------------------------------------------------------------
// Decimal text parser assertion macros
// Shared concurrent assertion macros for the decimal text parser.
// ---------------------------------------------------------------------------
`ifndef DECIMAL_TEXT_TO_INT32_PARSER_DEFINES_SVH
`define DECIMAL_TEXT_TO_INT32_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define DTP_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DTP_ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DTP_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define DTP_ASSERT_CLK(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/dtp_pkg.sv
// ---------------------------------------------------------------------------
// Decimal text parser package
// Types, constants and character codes shared by the parser modules.
// ---------------------------------------------------------------------------
package dtp_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [31:0] LIMIT_DIV10    = 32'd214748364;
  localparam logic [3:0]  LAST_DIGIT_NEG = 4'd8;
  localparam logic [3:0]  LAST_DIGIT_POS = 4'd7;
  localparam logic [3:0]  MAX_DIGITS     = 4'd10;
  localparam logic [7:0]  SIGN_MAX       = 8'hFF;
  localparam logic [15:0] MINUS_MAX      = 16'hFFFF;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  typedef enum logic [2:0] {
    K_OTHER,
    K_WS,
    K_PLUS,
    K_MINUS,
    K_DIGIT
  } kind_t;

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_SIGNS,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic       letter;
    logic [3:0] digit;
    logic       last;
  } entry_t;

  typedef struct packed {
    logic       overflow;
    logic       letter;
    logic [3:0] digit_count;
  } back_status_t;

endpackage

>>> rtl/decimal_text_to_int32_parser.sv
// ---------------------------------------------------------------------------
// Decimal text to int32 parser
// Parses a stream of characters into signed 32-bit integers, one per string.
//
//   Channel   Ports                                  Handshake
//   input     in_char_byte, in_end_of_string         push / full
//   result    out_value, out_overflow, out_no_digits empty / pop
//             out_letter_seen, out_sign_count,
//             out_minus_total
//
// One character is taken per cycle while the queue is not full; the back end
// also retires one queued character per cycle while it is not stalled.
// A result is on the result ports from the edge that takes its last character
// out of the queue. While a result waits, the back end stalls only on a final
// character and the queue keeps accepting input until it holds QUEUE_DEPTH
// entries. Reset is synchronous and clears the queue and all parse state.
// ---------------------------------------------------------------------------
`include "decimal_text_to_int32_parser_defines.svh"

module decimal_text_to_int32_parser #(
  parameter int unsigned QUEUE_DEPTH = dtp_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_char_byte,
  input  logic               in_end_of_string,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_value,
  output logic               out_overflow,
  output logic               out_no_digits,
  output logic               out_letter_seen,
  output logic [7:0]         out_sign_count,
  output logic [15:0]        out_minus_total
);

  dtp_pkg::entry_t       front_entry;
  dtp_pkg::entry_t       q_entry;
  dtp_pkg::back_status_t back_st;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;

  dtp_front u_front (
    .char_byte     (in_char_byte),
    .end_of_string (in_end_of_string),
    .entry         (front_entry)
  );

  dtp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (front_entry),
    .rd_en   (q_pop),
    .rd_data (q_entry),
    .full    (q_full),
    .empty   (q_empty)
  );

  dtp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (!q_empty),
    .q_entry     (q_entry),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .value       (out_value),
    .overflow    (out_overflow),
    .no_digits   (out_no_digits),
    .letter_seen (out_letter_seen),
    .sign_count  (out_sign_count),
    .minus_total (out_minus_total),
    .status      (back_st)
  );

  assign full = q_full;

  `DTP_ASSERT_RST(a_queue_state, clk, rst_n, !(q_full && q_empty), "Queue reports full and empty.")
  `DTP_ASSERT_RST(a_digit_bound, clk, rst_n, back_st.digit_count <= dtp_pkg::MAX_DIGITS, "Digit count passed its bound.")
  `DTP_ASSERT_RST(a_ovf_sticky, clk, rst_n, $past(rst_n) |-> !$fell(back_st.overflow), "Overflow flag cleared without reset.")
  `DTP_ASSERT_RST(a_stall_cause, clk, rst_n, (!q_empty && !q_pop) |-> (!empty && !pop), "Back end stalled with room for a result.")

endmodule

>>> rtl/dtp_front.sv
// ---------------------------------------------------------------------------
// Decimal text parser front end
// Classifies each incoming character into a compact queue entry.
// ---------------------------------------------------------------------------
module dtp_front (
  input  logic [7:0]      char_byte,
  input  logic            end_of_string,
  output dtp_pkg::entry_t entry
);

  logic is_digit;
  logic is_plus;
  logic is_minus;
  logic is_blank;
  logic is_ws;

  assign is_digit = (char_byte >= dtp_pkg::CHAR_ZERO) && (char_byte <= dtp_pkg::CHAR_NINE);
  assign is_plus  = (char_byte == dtp_pkg::CHAR_PLUS);
  assign is_minus = (char_byte == dtp_pkg::CHAR_MINUS);
  assign is_blank = (char_byte == dtp_pkg::CHAR_SPACE);
  assign is_ws    = is_blank ||
                    ((char_byte >= dtp_pkg::CHAR_TAB) && (char_byte <= dtp_pkg::CHAR_CR));

  always_comb begin
    if (is_digit) begin
      entry.kind = dtp_pkg::K_DIGIT;
    end else if (is_plus) begin
      entry.kind = dtp_pkg::K_PLUS;
    end else if (is_minus) begin
      entry.kind = dtp_pkg::K_MINUS;
    end else if (is_ws) begin
      entry.kind = dtp_pkg::K_WS;
    end else begin
      entry.kind = dtp_pkg::K_OTHER;
    end
    entry.letter = !(is_digit || is_plus || is_minus || is_blank);
    entry.digit  = char_byte[3:0];
    entry.last   = end_of_string;
  end

endmodule

>>> rtl/dtp_queue.sv
// ---------------------------------------------------------------------------
// Decimal text parser queue
// Small circular queue of classified characters between front and back.
// ---------------------------------------------------------------------------
module dtp_queue #(
  parameter int unsigned DEPTH = dtp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  dtp_pkg::entry_t wr_data,
  input  logic            rd_en,
  output dtp_pkg::entry_t rd_data,
  output logic            full,
  output logic            empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  dtp_pkg::entry_t mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_wr;
  logic            do_rd;

  assign full    = (count_r == CntFull);
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/dtp_back.sv
// ---------------------------------------------------------------------------
// Decimal text parser back end
// Runs the parse state machine and holds one finished result for transfer.
// ---------------------------------------------------------------------------
module dtp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  dtp_pkg::entry_t       q_entry,
  output logic                  q_pop,
  input  logic                  pop,
  output logic                  empty,
  output logic signed [31:0]    value,
  output logic                  overflow,
  output logic                  no_digits,
  output logic                  letter_seen,
  output logic [7:0]            sign_count,
  output logic [15:0]           minus_total,
  output dtp_pkg::back_status_t status
);

  dtp_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        neg_r, neg_nxt;
  logic [3:0]  dcnt_r, dcnt_nxt;
  logic [7:0]  scnt_r, scnt_nxt;
  logic [15:0] mcnt_r, mcnt_nxt;
  logic        ovf_r, ovf_nxt;
  logic        let_r, let_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_value_r;
  logic        out_ovf_r;
  logic        out_nod_r;
  logic        out_let_r;
  logic [7:0]  out_scnt_r;
  logic [15:0] out_mcnt_r;

  logic        deq;
  logic        take_sign;
  logic        take_digit;
  logic        over;
  logic [3:0]  last_digit;
  logic [31:0] acc_times_ten;
  logic [31:0] acc_step;
  logic [31:0] res_value;

  assign deq   = q_valid && (!q_entry.last || !out_valid_r || pop);
  assign q_pop = deq;

  always_comb begin
    take_sign  = 1'b0;
    take_digit = 1'b0;
    case (phase_r)
      dtp_pkg::PH_SPACE, dtp_pkg::PH_SIGNS: begin
        take_sign  = (q_entry.kind == dtp_pkg::K_PLUS) || (q_entry.kind == dtp_pkg::K_MINUS);
        take_digit = (q_entry.kind == dtp_pkg::K_DIGIT);
      end
      dtp_pkg::PH_DIGITS: begin
        take_digit = (q_entry.kind == dtp_pkg::K_DIGIT);
      end
      default: begin
        take_sign  = 1'b0;
        take_digit = 1'b0;
      end
    endcase
  end

  assign last_digit    = neg_r ? dtp_pkg::LAST_DIGIT_NEG : dtp_pkg::LAST_DIGIT_POS;
  assign over          = (dcnt_r >= dtp_pkg::MAX_DIGITS) ||
                         ((dcnt_r == dtp_pkg::MAX_DIGITS - 4'd1) &&
                          ((acc_r > dtp_pkg::LIMIT_DIV10) ||
                           ((acc_r == dtp_pkg::LIMIT_DIV10) && (q_entry.digit > last_digit))));
  assign acc_times_ten = {acc_r[28:0], 3'b000} + {acc_r[30:0], 1'b0};
  assign acc_step      = acc_times_ten + {28'd0, q_entry.digit};

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      dtp_pkg::PH_SPACE, dtp_pkg::PH_SIGNS: begin
        if (take_sign) begin
          phase_nxt = dtp_pkg::PH_SIGNS;
        end else if (take_digit) begin
          phase_nxt = over ? dtp_pkg::PH_DONE : dtp_pkg::PH_DIGITS;
        end else if (!((phase_r == dtp_pkg::PH_SPACE) && (q_entry.kind == dtp_pkg::K_WS))) begin
          phase_nxt = dtp_pkg::PH_DONE;
        end
      end
      dtp_pkg::PH_DIGITS: begin
        if (take_digit) begin
          phase_nxt = over ? dtp_pkg::PH_DONE : dtp_pkg::PH_DIGITS;
        end else begin
          phase_nxt = dtp_pkg::PH_DONE;
        end
      end
      default: begin
        phase_nxt = dtp_pkg::PH_DONE;
      end
    endcase
  end

  // Datapath updates for the accepted entry.
  always_comb begin
    acc_nxt  = acc_r;
    neg_nxt  = neg_r;
    dcnt_nxt = dcnt_r;
    scnt_nxt = scnt_r;
    mcnt_nxt = mcnt_r;
    ovf_nxt  = ovf_r;
    let_nxt  = let_r | q_entry.letter;
    if (take_sign) begin
      if (q_entry.kind == dtp_pkg::K_MINUS) begin
        neg_nxt = !neg_r;
        if (mcnt_r != dtp_pkg::MINUS_MAX) begin
          mcnt_nxt = mcnt_r + 16'd1;
        end
      end
      if (scnt_r != dtp_pkg::SIGN_MAX) begin
        scnt_nxt = scnt_r + 8'd1;
      end
    end
    if (take_digit) begin
      if (dcnt_r < dtp_pkg::MAX_DIGITS) begin
        dcnt_nxt = dcnt_r + 4'd1;
      end
      if (over) begin
        ovf_nxt = 1'b1;
        acc_nxt = '0;
        neg_nxt = 1'b0;
      end else begin
        acc_nxt = acc_step;
      end
    end
  end

  assign res_value     = neg_nxt ? (32'd0 - acc_nxt) : acc_nxt;
  assign out_valid_nxt = (deq && q_entry.last) ? 1'b1 : (out_valid_r && !pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dtp_pkg::PH_SPACE;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      dcnt_r      <= '0;
      scnt_r      <= '0;
      mcnt_r      <= '0;
      ovf_r       <= 1'b0;
      let_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (deq) begin
        mcnt_r <= mcnt_nxt;
        ovf_r  <= ovf_nxt;
        let_r  <= let_nxt;
        if (q_entry.last) begin
          phase_r <= dtp_pkg::PH_SPACE;
          acc_r   <= '0;
          neg_r   <= 1'b0;
          dcnt_r  <= '0;
          scnt_r  <= '0;
        end else begin
          phase_r <= phase_nxt;
          acc_r   <= acc_nxt;
          neg_r   <= neg_nxt;
          dcnt_r  <= dcnt_nxt;
          scnt_r  <= scnt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (deq && q_entry.last) begin
      out_value_r <= res_value;
      out_ovf_r   <= ovf_nxt;
      out_nod_r   <= (dcnt_nxt == 4'd0);
      out_let_r   <= let_nxt;
      out_scnt_r  <= scnt_nxt;
      out_mcnt_r  <= mcnt_nxt;
    end
  end

  assign empty       = !out_valid_r;
  assign value       = $signed(out_value_r);
  assign overflow    = out_ovf_r;
  assign no_digits   = out_nod_r;
  assign letter_seen = out_let_r;
  assign sign_count  = out_scnt_r;
  assign minus_total = out_mcnt_r;

  assign status.overflow    = ovf_r;
  assign status.letter      = let_r;
  assign status.digit_count = dcnt_r;

endmodule
